[rtl/gic_pkg.sv]
`timescale 1ns / 1ps

package gic_pkg;

  localparam int PadCount  = 4;
  localparam int PadW      = 2;
  localparam int BtnW      = 16;
  localparam int TrigW     = 8;
  localparam int AxW       = 16;
  localparam int DzW       = 15;
  localparam int QW        = 15;
  localparam int NumW      = 30;
  localparam int AxisCount = 4;
  localparam int AxSelW    = 2;
  localparam int DivSteps  = 15;
  localparam int StepW     = 4;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 15;
  localparam int MapCount  = 14;

  localparam logic [DzW-1:0]   FullScale   = 15'h7fff;
  localparam logic [DzW-1:0]   LeftDzRst   = 15'd7849;
  localparam logic [DzW-1:0]   RightDzRst  = 15'd8689;
  localparam logic [TrigW-1:0] TrigThrRst  = 8'd30;

  localparam logic [CfgIdxW-1:0] RegLeftDz  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRightDz = 2'd1;
  localparam logic [CfgIdxW-1:0] RegTrigThr = 2'd2;

  localparam int BitL2 = 14;
  localparam int BitR2 = 15;

  // raw bit feeding each held bit 0..13
  localparam logic [3:0] SrcBit [MapCount] = '{
    4'd12, 4'd13, 4'd14, 4'd15, 4'd8, 4'd9, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd0, 4'd1, 4'd2, 4'd3
  };

  typedef enum logic [2:0] {
    StIdle,
    StStart,
    StAxLoad,
    StAxCheck,
    StAxDiv,
    StAxStore,
    StWrite
  } gic_state_t;

  typedef struct packed {
    logic              capture;
    logic              ax_load;
    logic              ax_check;
    logic              div_step;
    logic              ax_store;
    logic              load_out;
    logic [AxSelW-1:0] ax_sel;
  } gic_cmd_t;

  typedef struct packed {
    logic pad_ok;
    logic conn;
    logic need_div;
  } gic_sts_t;

  typedef struct packed {
    logic [PadW-1:0]       pad_index;
    logic                  connected_in;
    logic [BtnW-1:0]       raw_buttons;
    logic [TrigW-1:0]      left_trigger_raw;
    logic [TrigW-1:0]      right_trigger_raw;
    logic signed [AxW-1:0] left_x_raw;
    logic signed [AxW-1:0] left_y_raw;
    logic signed [AxW-1:0] right_x_raw;
    logic signed [AxW-1:0] right_y_raw;
  } gic_in_word_t;

  typedef struct packed {
    logic                  connected;
    logic [BtnW-1:0]       held_buttons;
    logic [BtnW-1:0]       pressed_buttons;
    logic [BtnW-1:0]       released_buttons;
    logic signed [AxW-1:0] left_x;
    logic signed [AxW-1:0] left_y;
    logic signed [AxW-1:0] right_x;
    logic signed [AxW-1:0] right_y;
    logic [QW-1:0]         left_trigger;
    logic [QW-1:0]         right_trigger;
  } gic_out_word_t;

  function automatic logic [BtnW-1:0] remap_buttons(input logic [BtnW-1:0] raw,
                                                    input logic l2, input logic r2);
    logic [BtnW-1:0] held;
    held = '0;
    for (int k = 0; k < MapCount; k++) begin
      held[k] = raw[SrcBit[k]];
    end
    held[BitL2] = l2;
    held[BitR2] = r2;
    return held;
  endfunction

  // raw*32767/255 = raw*128 + raw*127/255; the /255 by reciprocal (exact below 2^15, which covers raw*127)
  function automatic logic [QW-1:0] scale_trigger(input logic [TrigW-1:0] raw);
    logic [QW-1:0] y;
    logic [QW:0]   s;
    logic [QW-1:0] q;
    y = {raw, 7'b0} - QW'(raw);
    s = {1'b0, y} + 16'd1 + 16'(y[QW-1:8]);
    q = QW'(s[QW:8]);
    return {raw, 7'b0} + q;
  endfunction

endpackage

[rtl/gic_in_if.sv]
`timescale 1ns / 1ps

interface gic_in_if;
  logic                           valid;
  logic                           ready;
  logic [gic_pkg::PadW-1:0]       pad_index;
  logic                           connected_in;
  logic [gic_pkg::BtnW-1:0]       raw_buttons;
  logic [gic_pkg::TrigW-1:0]      left_trigger_raw;
  logic [gic_pkg::TrigW-1:0]      right_trigger_raw;
  logic signed [gic_pkg::AxW-1:0] left_x_raw;
  logic signed [gic_pkg::AxW-1:0] left_y_raw;
  logic signed [gic_pkg::AxW-1:0] right_x_raw;
  logic signed [gic_pkg::AxW-1:0] right_y_raw;

  modport source (
    output valid, pad_index, connected_in, raw_buttons, left_trigger_raw,
           right_trigger_raw, left_x_raw, left_y_raw, right_x_raw, right_y_raw,
    input  ready
  );

  modport sink (
    input  valid, pad_index, connected_in, raw_buttons, left_trigger_raw,
           right_trigger_raw, left_x_raw, left_y_raw, right_x_raw, right_y_raw,
    output ready
  );
endinterface

[rtl/gic_out_if.sv]
`timescale 1ns / 1ps

interface gic_out_if;
  logic                           valid;
  logic                           ready;
  logic                           connected;
  logic [gic_pkg::BtnW-1:0]       held_buttons;
  logic [gic_pkg::BtnW-1:0]       pressed_buttons;
  logic [gic_pkg::BtnW-1:0]       released_buttons;
  logic signed [gic_pkg::AxW-1:0] left_x;
  logic signed [gic_pkg::AxW-1:0] left_y;
  logic signed [gic_pkg::AxW-1:0] right_x;
  logic signed [gic_pkg::AxW-1:0] right_y;
  logic [gic_pkg::QW-1:0]         left_trigger;
  logic [gic_pkg::QW-1:0]         right_trigger;

  modport source (
    output valid, connected, held_buttons, pressed_buttons, released_buttons,
           left_x, left_y, right_x, right_y, left_trigger, right_trigger,
    input  ready
  );

  modport sink (
    input  valid, connected, held_buttons, pressed_buttons, released_buttons,
           left_x, left_y, right_x, right_y, left_trigger, right_trigger,
    output ready
  );
endinterface

[rtl/gic_ctrl.sv]
`timescale 1ns / 1ps

module gic_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  gic_pkg::gic_sts_t sts,
  output gic_pkg::gic_cmd_t cmd
);

  localparam logic [gic_pkg::StepW-1:0]  StepLast = gic_pkg::StepW'(gic_pkg::DivSteps - 1);
  localparam logic [gic_pkg::AxSelW-1:0] AxLast   = gic_pkg::AxSelW'(gic_pkg::AxisCount - 1);

  gic_pkg::gic_state_t         state_r, state_nxt;
  logic [gic_pkg::AxSelW-1:0]  ax_r, ax_nxt;
  logic [gic_pkg::StepW-1:0]   step_r, step_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gic_pkg::StIdle;
      ax_r        <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ax_r        <= ax_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == gic_pkg::StIdle);

  always_comb begin
    state_nxt  = state_r;
    ax_nxt     = ax_r;
    step_nxt   = step_r;
    cmd        = '0;
    cmd.ax_sel = ax_r;
    unique case (state_r)
      gic_pkg::StIdle: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = gic_pkg::StStart;
        end
      end
      gic_pkg::StStart: begin
        if (!sts.pad_ok) begin
          state_nxt = gic_pkg::StIdle;
        end else if (!sts.conn) begin
          state_nxt = gic_pkg::StWrite;
        end else begin
          ax_nxt    = '0;
          state_nxt = gic_pkg::StAxLoad;
        end
      end
      gic_pkg::StAxLoad: begin
        cmd.ax_load = 1'b1;
        state_nxt   = gic_pkg::StAxCheck;
      end
      gic_pkg::StAxCheck: begin
        cmd.ax_check = 1'b1;
        if (sts.need_div) begin
          step_nxt  = '0;
          state_nxt = gic_pkg::StAxDiv;
        end else begin
          state_nxt = gic_pkg::StAxStore;
        end
      end
      gic_pkg::StAxDiv: begin
        cmd.div_step = 1'b1;
        if (step_r == StepLast) begin
          state_nxt = gic_pkg::StAxStore;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      gic_pkg::StAxStore: begin
        cmd.ax_store = 1'b1;
        if (ax_r == AxLast) begin
          state_nxt = gic_pkg::StWrite;
        end else begin
          ax_nxt    = ax_r + 1'b1;
          state_nxt = gic_pkg::StAxLoad;
        end
      end
      gic_pkg::StWrite: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = gic_pkg::StIdle;
        end
      end
      default: begin
        state_nxt = gic_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

[rtl/gic_dp.sv]
`timescale 1ns / 1ps

module gic_dp #(
  parameter int PAD_COUNT = gic_pkg::PadCount
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gic_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [gic_pkg::CfgDataW-1:0]  cfg_data,
  input  gic_pkg::gic_in_word_t         in_word,
  input  gic_pkg::gic_cmd_t             cmd,
  output gic_pkg::gic_sts_t             sts,
  output gic_pkg::gic_out_word_t        out_word
);

  localparam int PadIdxW = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
  localparam int DzW     = gic_pkg::DzW;
  localparam int QW      = gic_pkg::QW;
  localparam int AxW     = gic_pkg::AxW;
  localparam int NumW    = gic_pkg::NumW;
  localparam int BtnW    = gic_pkg::BtnW;

  logic [DzW-1:0]            ldz_r, rdz_r;
  logic [gic_pkg::TrigW-1:0] thr_r;

  logic [gic_pkg::PadW-1:0]  pad_r;
  logic                      conn_r;
  logic [BtnW-1:0]           held_r;
  logic [QW-1:0]             ltq_r, rtq_r;
  logic signed [AxW-1:0]     axraw_r [gic_pkg::AxisCount];
  logic signed [AxW-1:0]     axo_r [gic_pkg::AxisCount];
  logic [BtnW-1:0]           prev_r [PAD_COUNT];

  logic                      neg_r, below_r, full_r;
  logic [NumW-1:0]           num_r;
  logic [DzW-1:0]            den_r;
  logic [QW-1:0]             rem_r, rem_nxt;
  logic [QW-1:0]             qsh_r, qsh_nxt;
  gic_pkg::gic_out_word_t    out_r, out_nxt;

  logic [BtnW-1:0]           held_in;
  logic signed [AxW-1:0]     ax_raw;
  logic [DzW-1:0]            ax_dz;
  logic [AxW-1:0]            ax_mag;
  logic [AxW-1:0]            ax_off;
  logic                      sat;
  logic [QW:0]               trial;
  logic                      trial_ge;
  logic [PadIdxW-1:0]        pad_idx;
  logic [BtnW-1:0]           prev_cur;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ldz_r <= gic_pkg::LeftDzRst;
      rdz_r <= gic_pkg::RightDzRst;
      thr_r <= gic_pkg::TrigThrRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gic_pkg::RegLeftDz:  ldz_r <= cfg_data;
        gic_pkg::RegRightDz: rdz_r <= cfg_data;
        gic_pkg::RegTrigThr: thr_r <= cfg_data[gic_pkg::TrigW-1:0];
        default: ;
      endcase
    end
  end

  // capture of the input word
  assign held_in = gic_pkg::remap_buttons(in_word.raw_buttons,
                                          in_word.left_trigger_raw > thr_r,
                                          in_word.right_trigger_raw > thr_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pad_r      <= in_word.pad_index;
      conn_r     <= in_word.connected_in;
      held_r     <= held_in;
      ltq_r      <= gic_pkg::scale_trigger(in_word.left_trigger_raw);
      rtq_r      <= gic_pkg::scale_trigger(in_word.right_trigger_raw);
      axraw_r[0] <= in_word.left_x_raw;
      axraw_r[1] <= in_word.left_y_raw;
      axraw_r[2] <= in_word.right_x_raw;
      axraw_r[3] <= in_word.right_y_raw;
    end
  end

  assign sts.pad_ok = (int'(pad_r) < PAD_COUNT);
  assign sts.conn   = conn_r;

  // axis setup: magnitude, offset past deadzone, numerator = offset * 32767
  assign ax_raw = axraw_r[cmd.ax_sel];
  assign ax_dz  = cmd.ax_sel[1] ? rdz_r : ldz_r;
  assign ax_mag = ax_raw[AxW-1] ? (~ax_raw + 1'b1) : ax_raw;
  assign ax_off = ax_mag - {1'b0, ax_dz};

  always_ff @(posedge clk) begin
    if (cmd.ax_load) begin
      neg_r   <= ax_raw[AxW-1];
      below_r <= ax_mag < {1'b0, ax_dz};
      full_r  <= (ax_dz == gic_pkg::FullScale);
      num_r   <= NumW'({ax_off, 15'b0} - 31'(ax_off));
      den_r   <= gic_pkg::FullScale - ax_dz;
    end
  end

  // quotient would reach 32768 or more
  assign sat           = (num_r >= {den_r, 15'b0});
  assign sts.need_div  = !below_r && !full_r && !sat;

  // restoring divider, one quotient bit per step
  assign trial    = {rem_r, qsh_r[QW-1]};
  assign trial_ge = (trial >= {1'b0, den_r});

  always_comb begin
    rem_nxt = rem_r;
    qsh_nxt = qsh_r;
    if (cmd.ax_check) begin
      rem_nxt = num_r[NumW-1:QW];
      if (below_r) begin
        qsh_nxt = '0;
      end else if (full_r || sat) begin
        qsh_nxt = gic_pkg::FullScale;
      end else begin
        qsh_nxt = num_r[QW-1:0];
      end
    end else if (cmd.div_step) begin
      rem_nxt = trial_ge ? QW'(trial - {1'b0, den_r}) : trial[QW-1:0];
      qsh_nxt = {qsh_r[QW-2:0], trial_ge};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    qsh_r <= qsh_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.ax_store) begin
      axo_r[cmd.ax_sel] <= neg_r ? (AxW'(0) - {1'b0, qsh_r}) : {1'b0, qsh_r};
    end
  end

  // result and per-pad button history
  assign pad_idx  = PadIdxW'(pad_r);
  assign prev_cur = prev_r[pad_idx];

  always_comb begin
    out_nxt = '0;
    if (conn_r) begin
      out_nxt.connected        = 1'b1;
      out_nxt.held_buttons     = held_r;
      out_nxt.pressed_buttons  = held_r & ~prev_cur;
      out_nxt.released_buttons = prev_cur & ~held_r;
      out_nxt.left_x           = axo_r[0];
      out_nxt.left_y           = axo_r[1];
      out_nxt.right_x          = axo_r[2];
      out_nxt.right_y          = axo_r[3];
      out_nxt.left_trigger     = ltq_r;
      out_nxt.right_trigger    = rtq_r;
    end else begin
      out_nxt.released_buttons = prev_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PAD_COUNT; i++) begin
        prev_r[i] <= '0;
      end
    end else if (cmd.load_out) begin
      prev_r[pad_idx] <= conn_r ? held_r : '0;
    end
  end

  assign out_word = out_r;

endmodule

[rtl/gamepad_input_conditioner_core.sv]
`timescale 1ns / 1ps

// Gamepad input conditioner. Each input word is one poll of one pad; each accepted
// poll of a pad below PAD_COUNT gives one output word (a poll of a higher pad index
// is taken and dropped). Buttons are remapped with L2/R2 from the trigger threshold,
// pressed/released edges come from a per-pad history register, stick axes are
// deadzone-scaled to Q1.15, triggers to Q0.15. One poll is worked at a time; a
// disconnected pad skips the axis work, and a connected pad's time is set by the
// four stick axes going in turn through one shared restoring divider (setup,
// range check, 15 quotient steps only when the axis is outside the deadzone and
// not saturated, writeback). The next poll is taken while the previous output
// word waits in its register.
module gamepad_input_conditioner_core #(
  parameter int PAD_COUNT = gic_pkg::PadCount
) (
  input  logic                          clk,
  input  logic                          rst_n,
  gic_in_if.sink                        in_if,
  gic_out_if.source                     out_if,
  input  logic                          cfg_we,
  input  logic [gic_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [gic_pkg::CfgDataW-1:0]  cfg_data
);

  gic_pkg::gic_cmd_t      cmd;
  gic_pkg::gic_sts_t      sts;
  gic_pkg::gic_in_word_t  in_word;
  gic_pkg::gic_out_word_t out_word;

  assign in_word.pad_index         = in_if.pad_index;
  assign in_word.connected_in      = in_if.connected_in;
  assign in_word.raw_buttons       = in_if.raw_buttons;
  assign in_word.left_trigger_raw  = in_if.left_trigger_raw;
  assign in_word.right_trigger_raw = in_if.right_trigger_raw;
  assign in_word.left_x_raw        = in_if.left_x_raw;
  assign in_word.left_y_raw        = in_if.left_y_raw;
  assign in_word.right_x_raw       = in_if.right_x_raw;
  assign in_word.right_y_raw       = in_if.right_y_raw;

  gic_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gic_dp #(
    .PAD_COUNT (PAD_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_word  (out_word)
  );

  assign out_if.connected        = out_word.connected;
  assign out_if.held_buttons     = out_word.held_buttons;
  assign out_if.pressed_buttons  = out_word.pressed_buttons;
  assign out_if.released_buttons = out_word.released_buttons;
  assign out_if.left_x           = out_word.left_x;
  assign out_if.left_y           = out_word.left_y;
  assign out_if.right_x          = out_word.right_x;
  assign out_if.right_y          = out_word.right_y;
  assign out_if.left_trigger     = out_word.left_trigger;
  assign out_if.right_trigger    = out_word.right_trigger;

endmodule

[tb/sv/gic_poll_checker.sv]
`timescale 1ns / 1ps

module gic_poll_checker
  import gic_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  gic_in_if                   poll_mon,
  gic_out_if                  cond_mon,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  mismatches,
  output int                  words_checked,
  output int                  words_due
);

  logic [DzW-1:0]   left_dz;
  logic [DzW-1:0]   right_dz;
  logic [TrigW-1:0] trig_thr;
  logic [BtnW-1:0]  pad_history [PadCount];
  gic_out_word_t    due_q [$];

  function automatic logic [AxW-1:0] shape_axis(input logic signed [AxW-1:0] raw,
                                                input logic [DzW-1:0] dz);
    int     mag_in;
    longint mag;
    mag_in = (raw < 0) ? -int'(raw) : int'(raw);
    if (mag_in < int'(dz)) return '0;
    if (dz == FullScale) begin
      mag = 32767;
    end else begin
      mag = longint'(mag_in - int'(dz)) * 32767 / longint'(32767 - int'(dz));
      if (mag > 32767) mag = 32767;
    end
    return (raw < 0) ? AxW'(-mag) : AxW'(mag);
  endfunction

  function automatic logic [QW-1:0] trigger_q15(input logic [TrigW-1:0] raw);
    return QW'((int'(raw) * 32767) / 255);
  endfunction

  function automatic gic_out_word_t condition_poll(input gic_in_word_t p);
    gic_out_word_t   r;
    logic [BtnW-1:0] prev;
    logic [BtnW-1:0] held;
    r = '0;
    prev = pad_history[p.pad_index];
    if (!p.connected_in) begin
      r.released_buttons = prev;
      pad_history[p.pad_index] = '0;
      return r;
    end
    // own bit order: A B X Y L1 R1 START SELECT L3 R3 dpad L2 R2
    held = {p.right_trigger_raw > trig_thr, p.left_trigger_raw > trig_thr,
            p.raw_buttons[3:0], p.raw_buttons[7:4], p.raw_buttons[9:8],
            p.raw_buttons[15:12]};
    r.connected        = 1'b1;
    r.held_buttons     = held;
    r.pressed_buttons  = held & ~prev;
    r.released_buttons = prev & ~held;
    r.left_x           = shape_axis(p.left_x_raw, left_dz);
    r.left_y           = shape_axis(p.left_y_raw, left_dz);
    r.right_x          = shape_axis(p.right_x_raw, right_dz);
    r.right_y          = shape_axis(p.right_y_raw, right_dz);
    r.left_trigger     = trigger_q15(p.left_trigger_raw);
    r.right_trigger    = trigger_q15(p.right_trigger_raw);
    pad_history[p.pad_index] = held;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [BtnW-1:0] want,
                                      input logic [BtnW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    gic_in_word_t  poll;
    gic_out_word_t want;
    if (!rst_n) begin
      left_dz  = LeftDzRst;
      right_dz = RightDzRst;
      trig_thr = TrigThrRst;
      for (int i = 0; i < PadCount; i++) pad_history[i] = '0;
      due_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegLeftDz:  left_dz  = cfg_data[DzW-1:0];
          RegRightDz: right_dz = cfg_data[DzW-1:0];
          RegTrigThr: trig_thr = cfg_data[TrigW-1:0];
          default: ;
        endcase
      end
      if (cond_mon.valid && cond_mon.ready) begin
        words_checked++;
        if (due_q.size() == 0) begin
          $error("output word with no poll pending");
          mismatches++;
        end else begin
          want = due_q.pop_front();
          check_field("connected", BtnW'(want.connected), BtnW'(cond_mon.connected));
          check_field("held_buttons", want.held_buttons, cond_mon.held_buttons);
          check_field("pressed_buttons", want.pressed_buttons, cond_mon.pressed_buttons);
          check_field("released_buttons", want.released_buttons, cond_mon.released_buttons);
          check_field("left_x", want.left_x, cond_mon.left_x);
          check_field("left_y", want.left_y, cond_mon.left_y);
          check_field("right_x", want.right_x, cond_mon.right_x);
          check_field("right_y", want.right_y, cond_mon.right_y);
          check_field("left_trigger", BtnW'(want.left_trigger), BtnW'(cond_mon.left_trigger));
          check_field("right_trigger", BtnW'(want.right_trigger),
                      BtnW'(cond_mon.right_trigger));
        end
      end
      if (poll_mon.valid && poll_mon.ready) begin
        poll.pad_index         = poll_mon.pad_index;
        poll.connected_in      = poll_mon.connected_in;
        poll.raw_buttons       = poll_mon.raw_buttons;
        poll.left_trigger_raw  = poll_mon.left_trigger_raw;
        poll.right_trigger_raw = poll_mon.right_trigger_raw;
        poll.left_x_raw        = poll_mon.left_x_raw;
        poll.left_y_raw        = poll_mon.left_y_raw;
        poll.right_x_raw       = poll_mon.right_x_raw;
        poll.right_y_raw       = poll_mon.right_y_raw;
        // polls of a pad beyond the configured count are dropped
        if (int'(poll.pad_index) < PadCount) due_q.push_back(condition_poll(poll));
      end
    end
    words_due <= due_q.size();
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import gic_pkg::*;

  localparam int MaxCycles  = 400000;
  localparam int HoldCycles = 300;
  localparam int RandPhases = 6;
  localparam int PhaseItems = 90;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int                  mismatches;
  int                  words_checked;
  int                  words_due;
  int                  cycle_count = 0;
  int                  polls_sent = 0;
  bit                  src_gaps;
  bit                  snk_stalls;
  bit                  hold_out;
  logic [DzW-1:0]      left_dz_set;
  logic [DzW-1:0]      right_dz_set;
  logic [TrigW-1:0]    thr_set;
  logic [BtnW-1:0]     last_raw [PadCount];

  gic_in_if  poll_if();
  gic_out_if cond_if();

  gamepad_input_conditioner_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (poll_if),
    .out_if    (cond_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gic_poll_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .poll_mon      (poll_if),
    .cond_mon      (cond_if),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .words_checked (words_checked),
    .words_due     (words_due)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= MaxCycles) begin
      $display("gamepad_input_conditioner_core verification failed");
      $finish;
    end
  end

  task automatic offer_poll(input logic [PadW-1:0] pad, input logic conn,
                            input logic [BtnW-1:0] btn,
                            input logic [TrigW-1:0] lt, input logic [TrigW-1:0] rt,
                            input logic signed [AxW-1:0] lx, input logic signed [AxW-1:0] ly,
                            input logic signed [AxW-1:0] rx, input logic signed [AxW-1:0] ry);
    int gap;
    gap = src_gaps ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      poll_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    poll_if.valid             <= 1'b1;
    poll_if.pad_index         <= pad;
    poll_if.connected_in      <= conn;
    poll_if.raw_buttons       <= btn;
    poll_if.left_trigger_raw  <= lt;
    poll_if.right_trigger_raw <= rt;
    poll_if.left_x_raw        <= lx;
    poll_if.left_y_raw        <= ly;
    poll_if.right_x_raw       <= rx;
    poll_if.right_y_raw       <= ry;
    do @(posedge clk); while (!poll_if.ready);
    polls_sent++;
    last_raw[pad] = btn;
  endtask

  task automatic settle();
    poll_if.valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_regs(input logic [DzW-1:0] ldz, input logic [DzW-1:0] rdz,
                              input logic [TrigW-1:0] thr);
    cfg_we    <= 1'b1;
    cfg_index <= RegLeftDz;
    cfg_data  <= ldz;
    @(posedge clk);
    cfg_index <= RegRightDz;
    cfg_data  <= rdz;
    @(posedge clk);
    // junk above bit 7 must be dropped
    cfg_index <= RegTrigThr;
    cfg_data  <= {7'($urandom), thr};
    @(posedge clk);
    cfg_index <= RegUnused;
    cfg_data  <= CfgDataW'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    left_dz_set  = ldz;
    right_dz_set = rdz;
    thr_set      = thr;
  endtask

  function automatic logic signed [AxW-1:0] pick_axis(input logic [DzW-1:0] dz);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom_range(0, 65535) - 32768;
      3, 4: v = int'(dz) + $urandom_range(0, 4) - 2;
      5: begin
        case ($urandom_range(0, 4))
          0: v = -32768;
          1: v = 32767;
          2: v = -32767;
          3: v = 1;
          default: v = 0;
        endcase
      end
      6, 7: v = 32767 - $urandom_range(0, 300);
      default: v = $urandom_range(0, 2000);
    endcase
    if ($urandom_range(0, 1) != 0) v = -v;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return AxW'(v);
  endfunction

  function automatic logic [TrigW-1:0] pick_trigger();
    int v;
    case ($urandom_range(0, 3))
      0: v = int'(thr_set) + $urandom_range(0, 2) - 1;
      1: v = ($urandom_range(0, 1) != 0) ? 255 : 0;
      default: v = $urandom_range(0, 255);
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return TrigW'(v);
  endfunction

  task automatic random_poll();
    logic [PadW-1:0] pad;
    logic            conn;
    logic [BtnW-1:0] btn;
    pad  = PadW'($urandom_range(0, PadCount - 1));
    conn = ($urandom_range(0, 99) < 85);
    case ($urandom_range(0, 3))
      0: btn = BtnW'($urandom);
      1: btn = last_raw[pad] ^ (BtnW'(1) << $urandom_range(0, BtnW - 1));
      2: btn = last_raw[pad];
      default: btn = ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
    endcase
    offer_poll(pad, conn, btn, pick_trigger(), pick_trigger(),
               pick_axis(left_dz_set), pick_axis(left_dz_set),
               pick_axis(right_dz_set), pick_axis(right_dz_set));
  endtask

  // output side
  initial begin
    int stall;
    cond_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_out) begin
        cond_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        stall = snk_stalls ? $urandom_range(0, 15) : 0;
        if (stall != 0) begin
          cond_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      cond_if.ready <= 1'b1;
      do @(posedge clk); while (!cond_if.valid);
    end
  end

  initial begin
    logic [DzW-1:0]   ldz;
    logic [DzW-1:0]   rdz;
    logic [TrigW-1:0] thr;
    rst_n                     <= 1'b0;
    cfg_we                    <= 1'b0;
    cfg_index                 <= RegLeftDz;
    cfg_data                  <= '0;
    poll_if.valid             <= 1'b0;
    poll_if.pad_index         <= '0;
    poll_if.connected_in      <= 1'b0;
    poll_if.raw_buttons       <= '0;
    poll_if.left_trigger_raw  <= '0;
    poll_if.right_trigger_raw <= '0;
    poll_if.left_x_raw        <= '0;
    poll_if.left_y_raw        <= '0;
    poll_if.right_x_raw       <= '0;
    poll_if.right_y_raw       <= '0;
    src_gaps     = 1'b1;
    snk_stalls   = 1'b1;
    hold_out     = 1'b0;
    left_dz_set  = LeftDzRst;
    right_dz_set = RightDzRst;
    thr_set      = TrigThrRst;
    for (int i = 0; i < PadCount; i++) last_raw[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: deadzone and threshold edges, full press/release, absent pads
    offer_poll(0, 1, 16'h0000, 0, 0, 0, 0, 0, 0);
    offer_poll(0, 1, 16'hffff, 255, 255, 32767, -32768, -32767, 0);
    offer_poll(0, 1, 16'h0000, 30, 31, 7849, -7849, 8688, -8689);
    offer_poll(0, 1, 16'h0c00, 31, 30, 7848, -7850, 8690, -8688);
    offer_poll(1, 1, 16'h5555, 0, 128, 1, -1, 16384, -16384);
    offer_poll(1, 1, 16'haaaa, 200, 29, -32767, 32766, -32768, 32767);
    offer_poll(1, 0, 16'hffff, 255, 255, 32767, 32767, -32768, -32768);
    offer_poll(1, 0, 16'h1234, 0, 0, 0, 0, 0, 0);
    offer_poll(2, 0, 16'h0000, 10, 10, 100, 100, 100, 100);
    offer_poll(3, 1, 16'hf3ff, 255, 0, -32768, -32768, -32768, -32768);
    offer_poll(3, 1, 16'h0001, 0, 255, 12000, -12000, 20000, -20000);
    offer_poll(2, 1, 16'h1000, 1, 254, -9000, 9000, -7000, 7000);
    offer_poll(3, 1, 16'h8000, 31, 31, 32767, 32767, 32767, 32767);
    settle();

    for (int ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        0: begin ldz = '0; rdz = FullScale; thr = 8'h00; end
        1: begin ldz = FullScale; rdz = '0; thr = 8'hff; end
        2: begin
          ldz = 15'd32766;
          rdz = 15'd1;
          thr = 8'hfe;
          hold_out = 1'b1;
        end
        default: begin
          ldz = DzW'($urandom);
          rdz = DzW'($urandom);
          thr = TrigW'($urandom);
        end
      endcase
      src_gaps   = (ph != 3);
      snk_stalls = (ph != 3);
      program_regs(ldz, rdz, thr);
      repeat (PhaseItems) random_poll();
      settle();
    end

    repeat (20) @(posedge clk);
    $display("Ran %0d polls across %0d register settings, one %0d-cycle output hold",
             polls_sent, RandPhases + 1, HoldCycles);
    $display("Checked %0d output words, %0d field mismatches", words_checked, mismatches);
    if (mismatches == 0 && words_due == 0) begin
      $display("gamepad_input_conditioner_core verification clean");
    end else begin
      $display("gamepad_input_conditioner_core verification failed");
    end
    $finish;
  end

endmodule
